### hdl/oues_pkg.sv
// Shared types, constants and fixed-point helpers for the active OU particle step block.
// Used by oues_cfg and active_ou_particle_euler_step; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package oues_pkg;

  localparam int unsigned MAX_PARTICLES_DEF = 1024;
  localparam int unsigned MAX_AXES_DEF = 4;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORCE_GAIN    = 3'd0,
    CFG_THERMAL_GAIN  = 3'd1,
    CFG_OU_DECAY      = 3'd2,
    CFG_OU_NOISE_GAIN = 3'd3,
    CFG_INV_DT        = 3'd4,
    CFG_ACTIVE_ON     = 3'd5,
    CFG_THERMAL_ON    = 3'd6
  } cfg_idx_e;

  localparam logic [30:0] FORCE_GAIN_RST = 31'd655;
  localparam logic [30:0] THERMAL_GAIN_RST = 31'd0;
  localparam logic [16:0] OU_DECAY_RST = 17'd655;
  localparam logic [30:0] OU_NOISE_GAIN_RST = 31'd0;
  localparam logic [30:0] INV_DT_RST = 31'd6553600;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // 10000.0 in Q16.16.
  localparam logic signed [31:0] FORCE_LIMIT = 32'sd655360000;

  typedef struct packed {
    logic [30:0] force_gain;
    logic [30:0] thermal_gain;
    logic [16:0] ou_decay;
    logic [30:0] ou_noise_gain;
    logic [30:0] inv_dt;
    logic        active_on;
    logic        thermal_on;
  } cfg_t;

  // Round to nearest with ties toward plus infinity, then drop k fraction bits.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                   input int unsigned k);
    logic signed [63:0] half;
    half = 64'sd1 <<< (k - 1);
    return (x + half) >>> k;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/oues_cfg.sv
// Configuration register file for the active OU particle step block.
// Depends on oues_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module oues_cfg
  import oues_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.force_gain    <= FORCE_GAIN_RST;
      cfg_q.thermal_gain  <= THERMAL_GAIN_RST;
      cfg_q.ou_decay      <= OU_DECAY_RST;
      cfg_q.ou_noise_gain <= OU_NOISE_GAIN_RST;
      cfg_q.inv_dt        <= INV_DT_RST;
      cfg_q.active_on     <= 1'b0;
      cfg_q.thermal_on    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FORCE_GAIN:    cfg_q.force_gain    <= cfg_wdata_i;
        CFG_THERMAL_GAIN:  cfg_q.thermal_gain  <= cfg_wdata_i;
        CFG_OU_DECAY:      cfg_q.ou_decay      <= cfg_wdata_i[16:0];
        CFG_OU_NOISE_GAIN: cfg_q.ou_noise_gain <= cfg_wdata_i;
        CFG_INV_DT:        cfg_q.inv_dt        <= cfg_wdata_i;
        CFG_ACTIVE_ON:     cfg_q.active_on     <= cfg_wdata_i[0];
        CFG_THERMAL_ON:    cfg_q.thermal_on    <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hdl/active_ou_particle_euler_step.sv
// Top level of the active OU particle Euler-Maruyama step: stores, pipeline and stream ports.
// Depends on oues_pkg and instantiates oues_cfg.
//
// Channel   Dir  Bus           Content
// s_axis    in   stream        one load or step command per transfer
// m_axis    out  stream        one result per accepted command, in order
// cfg       in   write port    seven registers; user writes only while block idle, unenforced
//
// One transfer is accepted per cycle unless a hazard or a full pipeline holds the input.
// A command whose entry is still being updated by one of the three commands before it
// waits until that write-back to the position and propulsion memories lands.
// Reset empties the pipeline and sets the registers to their reset values; the memories are not cleared.
// Each pipeline stage holds its item while the stage after it is full and cannot move on, so bubbles are absorbed.
`timescale 1ns / 1ps
`default_nettype none

module active_ou_particle_euler_step
  import oues_pkg::*;
#(
  parameter int unsigned MAX_PARTICLES = MAX_PARTICLES_DEF,
  parameter int unsigned MAX_AXES      = MAX_AXES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // particle[9:0], axis[11:10], force_req[43:12], init_position[75:44],
  // init_propulsion[107:76], noise_thermal[123:108], noise_active[139:124]
  input  wire logic [143:0]          s_axis_tdata,
  // cmd[0]
  input  wire logic [0:0]            s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // new_position[31:0], velocity[63:32], new_propulsion[95:64], force_large[96]
  output logic [103:0]               m_axis_tdata,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned DEPTH = MAX_PARTICLES * MAX_AXES;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t cfg;

  oues_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Input fields.
  logic              in_cmd;
  logic [9:0]        in_particle;
  logic [1:0]        in_axis;
  logic signed [31:0] in_force;
  logic signed [31:0] in_ipos;
  logic signed [31:0] in_iprop;
  logic signed [15:0] in_nth;
  logic signed [15:0] in_nac;
  logic              in_ok;
  logic [26:0]       in_addr_full;
  logic [AW-1:0]     in_addr;

  assign in_cmd      = s_axis_tuser[0];
  assign in_particle = s_axis_tdata[9:0];
  assign in_axis     = s_axis_tdata[11:10];
  assign in_force    = s_axis_tdata[43:12];
  assign in_ipos     = s_axis_tdata[75:44];
  assign in_iprop    = s_axis_tdata[107:76];
  assign in_nth      = s_axis_tdata[123:108];
  assign in_nac      = s_axis_tdata[139:124];

  assign in_ok = ({22'd0, in_particle} < 32'(MAX_PARTICLES)) &&
                 ({30'd0, in_axis} < 32'(MAX_AXES));
  assign in_addr_full = 27'(in_particle) * 27'(MAX_AXES) + 27'(in_axis);
  assign in_addr = in_ok ? in_addr_full[AW-1:0] : '0;

  // Stage registers.
  logic              v1_q, v2_q, v3_q, v4_q, out_v_q;
  logic              s1_cmd_q, s1_wr_q;
  logic [AW-1:0]     s1_addr_q;
  logic signed [31:0] s1_force_q, s1_ipos_q, s1_iprop_q;
  logic signed [15:0] s1_nth_q, s1_nac_q;
  logic signed [31:0] rd_pos_q, rd_prop_q;

  logic              s2_cmd_q, s2_wr_q, s2_big_q;
  logic [AW-1:0]     s2_addr_q;
  logic signed [31:0] s2_pos_q, s2_p_q;
  logic signed [62:0] s2_fprod_q, s2_pprod_q;
  logic signed [48:0] s2_dprod_q;
  logic signed [46:0] s2_nprod_q, s2_tprod_q;

  logic              s3_wr_q, s3_big_q;
  logic [AW-1:0]     s3_addr_q;
  logic signed [31:0] s3_pos_q, s3_incr_q, s3_newp_q;

  logic              s4_big_q;
  logic signed [31:0] s4_newpos_q, s4_newp_q;
  logic signed [62:0] s4_vprod_q;

  logic [103:0]      out_data_q;

  logic signed [31:0] pos_mem [DEPTH];
  logic signed [31:0] prop_mem [DEPTH];

  // Flow control.
  logic out_free, en1, en2, en3, en4, hazard, accept, mem_we;

  assign out_free = !out_v_q || m_axis_tready;
  assign en4 = !v4_q || out_free;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign hazard = in_ok && ((v1_q && s1_wr_q && (s1_addr_q == in_addr)) ||
                            (v2_q && s2_wr_q && (s2_addr_q == in_addr)) ||
                            (v3_q && s3_wr_q && (s3_addr_q == in_addr)));

  assign s_axis_tready = en1 && !hazard;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign mem_we = v3_q && en4 && s3_wr_q;

  // Stage 1 logic: pick the operands and form the products.
  logic signed [31:0] s1_pos, s1_p;
  logic              s1_big;
  logic signed [62:0] s1_fprod, s1_pprod;
  logic signed [48:0] s1_dprod;
  logic signed [46:0] s1_nprod, s1_tprod;

  always_comb begin
    if (s1_cmd_q == CMD_STEP) begin
      s1_pos = s1_wr_q ? rd_pos_q : 32'sd0;
      s1_p   = s1_wr_q ? rd_prop_q : 32'sd0;
    end else begin
      s1_pos = s1_ipos_q;
      s1_p   = s1_iprop_q;
    end
    s1_big = (s1_cmd_q == CMD_STEP) &&
             ((s1_force_q > FORCE_LIMIT) || (s1_force_q < -FORCE_LIMIT));
    s1_fprod = 63'(s1_force_q) * 63'($signed({1'b0, cfg.force_gain}));
    s1_pprod = 63'(s1_p) * 63'($signed({1'b0, cfg.force_gain}));
    s1_dprod = 49'(s1_p) * 49'($signed({1'b0, cfg.ou_decay}));
    s1_nprod = 47'($signed({1'b0, cfg.ou_noise_gain})) * 47'(s1_nac_q);
    s1_tprod = 47'($signed({1'b0, cfg.thermal_gain})) * 47'(s1_nth_q);
  end

  // Stage 2 logic: rounded terms, increment and new propulsion.
  logic signed [49:0] s2_incr_sum;
  logic signed [37:0] s2_np_sum;
  logic signed [31:0] s2_incr, s2_newp;

  always_comb begin
    s2_incr_sum = 50'(rnd_shift(64'(s2_fprod_q), 16));
    if (cfg.active_on) begin
      s2_incr_sum = s2_incr_sum + 50'(rnd_shift(64'(s2_pprod_q), 16));
    end
    if (cfg.thermal_on) begin
      s2_incr_sum = s2_incr_sum + 50'(rnd_shift(64'(s2_tprod_q), 12));
    end
    s2_np_sum = 38'(s2_p_q) - 38'(rnd_shift(64'(s2_dprod_q), 16))
              + 38'(rnd_shift(64'(s2_nprod_q), 12));
    if (s2_cmd_q == CMD_STEP) begin
      s2_incr = sat32(64'(s2_incr_sum));
      s2_newp = cfg.active_on ? sat32(64'(s2_np_sum)) : s2_p_q;
    end else begin
      s2_incr = 32'sd0;
      s2_newp = s2_p_q;
    end
  end

  // Stage 3 logic: new position and the velocity product.
  logic signed [31:0] s3_newpos;
  logic signed [62:0] s3_vprod;

  assign s3_newpos = sat32(64'(s3_pos_q) + 64'(s3_incr_q));
  assign s3_vprod  = 63'(s3_incr_q) * 63'($signed({1'b0, cfg.inv_dt}));

  // Stage 4 logic: velocity rounding.
  logic signed [31:0] s4_vel;

  assign s4_vel = sat32(rnd_shift(64'(s4_vprod_q), 16));

  // Position and propulsion memories: one read and one write port each.
  always_ff @(posedge clk_i) begin
    if (en1) begin
      rd_pos_q  <= pos_mem[in_addr];
      rd_prop_q <= prop_mem[in_addr];
    end
    if (mem_we) begin
      pos_mem[s3_addr_q]  <= s3_newpos;
      prop_mem[s3_addr_q] <= s3_newp_q;
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= accept;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
      if (out_free) begin
        out_v_q <= v4_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_cmd_q   <= in_cmd;
      s1_wr_q    <= in_ok;
      s1_addr_q  <= in_addr;
      s1_force_q <= in_force;
      s1_ipos_q  <= in_ipos;
      s1_iprop_q <= in_iprop;
      s1_nth_q   <= in_nth;
      s1_nac_q   <= in_nac;
    end
    if (en2) begin
      s2_cmd_q   <= s1_cmd_q;
      s2_wr_q    <= s1_wr_q;
      s2_addr_q  <= s1_addr_q;
      s2_big_q   <= s1_big;
      s2_pos_q   <= s1_pos;
      s2_p_q     <= s1_p;
      s2_fprod_q <= s1_fprod;
      s2_pprod_q <= s1_pprod;
      s2_dprod_q <= s1_dprod;
      s2_nprod_q <= s1_nprod;
      s2_tprod_q <= s1_tprod;
    end
    if (en3) begin
      s3_wr_q   <= s2_wr_q;
      s3_addr_q <= s2_addr_q;
      s3_big_q  <= s2_big_q;
      s3_pos_q  <= s2_pos_q;
      s3_incr_q <= s2_incr;
      s3_newp_q <= s2_newp;
    end
    if (en4) begin
      s4_big_q    <= s3_big_q;
      s4_newpos_q <= s3_newpos;
      s4_newp_q   <= s3_newp_q;
      s4_vprod_q  <= s3_vprod;
    end
    if (out_free) begin
      out_data_q <= {7'd0, s4_big_q, s4_newp_q, s4_vel, s4_newpos_q};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

### bench/tb_active_ou_particle_euler_step.sv
// Testbench for the active OU particle Euler-Maruyama step block: directed and random
// load and step transfers, checked against an in-bench fixed-point predictor.
// Depends on oues_pkg and active_ou_particle_euler_step.
`timescale 1ns / 1ps

module tb_active_ou_particle_euler_step;
  import oues_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
  localparam longint FORCE_WARN_Q16 = 64'sd655360000;
  localparam int TIMEOUT_NS = 1_000_000;

  typedef struct {
    logic               cmd;
    logic [9:0]         particle;
    logic [1:0]         axis;
    logic signed [31:0] force_req;
    logic signed [31:0] init_position;
    logic signed [31:0] init_propulsion;
    logic signed [15:0] noise_thermal;
    logic signed [15:0] noise_active;
  } ou_cmd_t;

  typedef struct {
    logic signed [31:0] new_position;
    logic signed [31:0] velocity;
    logic signed [31:0] new_propulsion;
    logic               force_large;
  } ou_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [143:0]          s_axis_tdata = '0;
  logic [0:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [103:0]          m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // Predictor copy of the registers.
  logic [30:0] gain_force = FORCE_GAIN_RST;
  logic [30:0] gain_thermal = THERMAL_GAIN_RST;
  logic [16:0] decay_ou = OU_DECAY_RST;
  logic [30:0] gain_ou_noise = OU_NOISE_GAIN_RST;
  logic [30:0] rate_inv_dt = INV_DT_RST;
  logic        mode_active = 1'b0;
  logic        mode_thermal = 1'b0;

  // Predictor copy of the particle stores, plus the entries that hold a loaded value.
  logic signed [31:0] position_mem[int];
  logic signed [31:0] propulsion_mem[int];
  int                 loaded_entries[$];

  ou_result_t pending_updates[$];
  int         error_count = 0;
  bit         src_idle_en = 1'b1;
  bit         sink_idle_en = 1'b1;
  bit         sink_hold = 1'b0;
  int         sink_stall_left = 0;

  active_ou_particle_euler_step u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

  // Rounds a fixed-point product to nearest, ties toward plus infinity.
  function automatic longint round_q(input longint x, input int k);
    return (x >>> k) + ((x >>> (k - 1)) & 64'sd1);
  endfunction

  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic ou_result_t advance_particle(input ou_cmd_t c);
    ou_result_t r;
    int         entry;
    longint     pos;
    longint     prop;
    longint     frc;
    longint     incr;
    longint     next_prop;
    longint     mag;
    entry = int'(c.particle) * 4 + int'(c.axis);
    if (c.cmd == CMD_LOAD) begin
      if (!position_mem.exists(entry)) begin
        loaded_entries.push_back(entry);
      end
      position_mem[entry] = c.init_position;
      propulsion_mem[entry] = c.init_propulsion;
      r.new_position = c.init_position;
      r.velocity = '0;
      r.new_propulsion = c.init_propulsion;
      r.force_large = 1'b0;
      return r;
    end
    pos = position_mem.exists(entry) ? longint'(position_mem[entry]) : 0;
    prop = propulsion_mem.exists(entry) ? longint'(propulsion_mem[entry]) : 0;
    frc = longint'(c.force_req);
    incr = round_q(frc * longint'(gain_force), 16);
    next_prop = prop;
    if (mode_active) begin
      incr += round_q(prop * longint'(gain_force), 16);
      next_prop = clamp32(prop - round_q(prop * longint'(decay_ou), 16)
                          + round_q(longint'(gain_ou_noise) * longint'(c.noise_active), 12));
    end
    if (mode_thermal) begin
      incr += round_q(longint'(gain_thermal) * longint'(c.noise_thermal), 12);
    end
    incr = clamp32(incr);
    mag = (frc < 0) ? -frc : frc;
    r.new_position = 32'(clamp32(pos + incr));
    r.velocity = 32'(clamp32(round_q(incr * longint'(rate_inv_dt), 16)));
    r.new_propulsion = 32'(next_prop);
    r.force_large = (mag > FORCE_WARN_Q16);
    position_mem[entry] = r.new_position;
    propulsion_mem[entry] = r.new_propulsion;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    ou_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_updates.size() == 0) begin
        report_mismatch("unexpected result transfer", longint'(m_axis_tdata[31:0]), 0);
      end else begin
        want = pending_updates.pop_front();
        if ($signed(m_axis_tdata[31:0]) !== want.new_position) begin
          report_mismatch("new_position", longint'($signed(m_axis_tdata[31:0])),
                          longint'(want.new_position));
        end
        if ($signed(m_axis_tdata[63:32]) !== want.velocity) begin
          report_mismatch("velocity", longint'($signed(m_axis_tdata[63:32])),
                          longint'(want.velocity));
        end
        if ($signed(m_axis_tdata[95:64]) !== want.new_propulsion) begin
          report_mismatch("new_propulsion", longint'($signed(m_axis_tdata[95:64])),
                          longint'(want.new_propulsion));
        end
        if (m_axis_tdata[96] !== want.force_large) begin
          report_mismatch("force_large", longint'(m_axis_tdata[96]),
                          longint'(want.force_large));
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (sink_stall_left != 0) begin
      sink_stall_left--;
    end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
      sink_stall_left = $urandom_range(1, 5);
    end
    m_axis_tready <= !sink_hold && (sink_stall_left == 0);
  end

  task automatic send_command(input ou_cmd_t c);
    int gap;
    @(negedge clk_i);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= c.cmd;
    s_axis_tdata <= {4'b0, c.noise_active, c.noise_thermal, c.init_propulsion,
                     c.init_position, c.force_req, c.axis, c.particle};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_updates.push_back(advance_particle(c));
  endtask

  task automatic wait_until_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_FORCE_GAIN:    gain_force = value;
      CFG_THERMAL_GAIN:  gain_thermal = value;
      CFG_OU_DECAY:      decay_ou = value[16:0];
      CFG_OU_NOISE_GAIN: gain_ou_noise = value;
      CFG_INV_DT:        rate_inv_dt = value;
      CFG_ACTIVE_ON:     mode_active = value[0];
      CFG_THERMAL_ON:    mode_thermal = value[0];
      default:           ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic ou_cmd_t make_command(input logic cmd, input int particle, input int axis,
                                           input logic [31:0] frc, input logic [31:0] pos,
                                           input logic [31:0] prop, input logic [15:0] nth,
                                           input logic [15:0] nac);
    ou_cmd_t c;
    c.cmd = cmd;
    c.particle = particle[9:0];
    c.axis = axis[1:0];
    c.force_req = frc;
    c.init_position = pos;
    c.init_propulsion = prop;
    c.noise_thermal = nth;
    c.noise_active = nac;
    return c;
  endfunction

  function automatic logic [31:0] draw_q16();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3, 4: return $urandom;
      default: return 32'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
    endcase
  endfunction

  function automatic logic [15:0] draw_noise();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       return 16'h7fff;
      1:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly steps on loaded entries, many on recently loaded ones so that updates collide.
  function automatic ou_cmd_t draw_command();
    int entry;
    int n;
    n = loaded_entries.size();
    if (n == 0 || $urandom_range(0, 3) == 0) begin
      entry = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4095);
      return make_command(CMD_LOAD, entry / 4, entry % 4, $urandom, draw_q16(), draw_q16(),
                          16'($urandom), 16'($urandom));
    end
    if ($urandom_range(0, 1) == 0) begin
      entry = loaded_entries[$urandom_range((n > 8) ? n - 8 : 0, n - 1)];
    end else begin
      entry = loaded_entries[$urandom_range(0, n - 1)];
    end
    return make_command(CMD_STEP, entry / 4, entry % 4, draw_q16(), $urandom, $urandom,
                        draw_noise(), draw_noise());
  endfunction

  function automatic logic [30:0] draw_gain();
    int pick;
    pick = $urandom_range(0, 7);
    case (pick)
      0:       return '0;
      1:       return 31'h7fff_ffff;
      default: return 31'($urandom_range(1, 1 << 18));
    endcase
  endfunction

  task automatic randomize_settings();
    int pick;
    logic [30:0] decay;
    pick = $urandom_range(0, 7);
    case (pick)
      0:       decay = 31'd0;
      1:       decay = 31'd65536;
      2:       decay = 31'($urandom_range(65537, 131071));
      default: decay = 31'($urandom_range(0, 65536));
    endcase
    write_register(CFG_FORCE_GAIN, draw_gain());
    write_register(CFG_THERMAL_GAIN, draw_gain());
    write_register(CFG_OU_DECAY, decay);
    write_register(CFG_OU_NOISE_GAIN, draw_gain());
    write_register(CFG_INV_DT, ($urandom_range(0, 7) == 0) ? 31'h7fff_ffff :
                               31'($urandom_range(0, 1 << 24)));
    write_register(CFG_ACTIVE_ON, 31'($urandom_range(0, 1)));
    write_register(CFG_THERMAL_ON, 31'($urandom_range(0, 1)));
  endtask

  task automatic test_load_extremes();
    send_command(make_command(CMD_LOAD, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 0));
    send_command(make_command(CMD_LOAD, 1023, 3, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                              16'hffff, 16'hffff));
    send_command(make_command(CMD_STEP, 0, 0, 32'h7fff_ffff, 0, 0, 16'h7fff, 16'h7fff));
    send_command(make_command(CMD_STEP, 1023, 3, 32'h8000_0000, 0, 0, 16'h8000, 16'h8000));
    send_command(make_command(CMD_STEP, 0, 0, 32'd655360000, 0, 0, 0, 0));
    send_command(make_command(CMD_STEP, 0, 0, -32'sd655360001, 0, 0, 0, 0));
  endtask

  task automatic test_register_extremes();
    wait_until_idle();
    write_register(CFG_FORCE_GAIN, 31'h7fff_ffff);
    write_register(CFG_THERMAL_GAIN, 31'h7fff_ffff);
    write_register(CFG_OU_DECAY, 31'd65536);
    write_register(CFG_OU_NOISE_GAIN, 31'h7fff_ffff);
    write_register(CFG_INV_DT, 31'h7fff_ffff);
    write_register(CFG_ACTIVE_ON, 31'd1);
    write_register(CFG_THERMAL_ON, 31'd1);
    write_register(CFG_IDX_UNUSED, 31'h5555_5555);
    send_command(make_command(CMD_LOAD, 512, 1, 0, 0, 32'h7fff_ffff, 0, 0));
    send_command(make_command(CMD_STEP, 512, 1, 32'h7fff_ffff, 0, 0, 16'h7fff, 16'h7fff));
    send_command(make_command(CMD_STEP, 512, 1, 32'h8000_0000, 0, 0, 16'h8000, 16'h8000));
    wait_until_idle();
    // A decay above one overshoots zero; zero gains leave only the propulsion noise path.
    write_register(CFG_OU_DECAY, 31'd131071);
    write_register(CFG_FORCE_GAIN, 31'd0);
    write_register(CFG_INV_DT, 31'd0);
    write_register(CFG_THERMAL_GAIN, 31'd0);
    write_register(CFG_OU_NOISE_GAIN, 31'd4096);
    send_command(make_command(CMD_LOAD, 256, 2, 0, -32'sd5, 32'h1234_5678, 0, 0));
    send_command(make_command(CMD_STEP, 256, 2, 1, 0, 0, 0, 16'h1000));
    send_command(make_command(CMD_STEP, 256, 2, 0, 0, 0, 0, 16'hf000));
  endtask

  task automatic test_update_hazards();
    wait_until_idle();
    src_idle_en = 1'b0;
    write_register(CFG_FORCE_GAIN, 31'd65536);
    write_register(CFG_THERMAL_GAIN, 31'd300);
    write_register(CFG_OU_DECAY, 31'd6554);
    write_register(CFG_OU_NOISE_GAIN, 31'd1000);
    write_register(CFG_INV_DT, 31'd655360);
    send_command(make_command(CMD_LOAD, 5, 2, 0, 32'h0001_0000, 32'h0002_0000, 0, 0));
    send_command(make_command(CMD_STEP, 5, 2, 32'h0000_8000, 0, 0, 16'h0800, 16'h1000));
    send_command(make_command(CMD_STEP, 5, 2, 32'hffff_0000, 0, 0, 16'hf800, 16'h0400));
    send_command(make_command(CMD_LOAD, 6, 1, 0, 32'h0100_0000, 32'hff00_0000, 0, 0));
    send_command(make_command(CMD_STEP, 5, 2, 32'h0003_0000, 0, 0, 16'h2000, 16'hc000));
    send_command(make_command(CMD_STEP, 6, 1, 32'h0000_1000, 0, 0, 16'h0001, 16'h7fff));
    send_command(make_command(CMD_LOAD, 5, 2, 0, 32'hfff0_0000, 32'h0000_0100, 0, 0));
    send_command(make_command(CMD_STEP, 5, 2, 32'h0000_0001, 0, 0, 16'h0000, 16'h0000));
    src_idle_en = 1'b1;
  endtask

  task automatic test_output_backpressure();
    wait_until_idle();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    sink_hold = 1'b1;
    fork
      begin
        repeat (60) @(posedge clk_i);
        sink_hold = 1'b0;
      end
    join_none
    repeat (30) send_command(draw_command());
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      wait_until_idle();
      randomize_settings();
      if (phase == 4) begin
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
      end
      repeat (120) send_command(draw_command());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_load_extremes();
    test_register_extremes();
    test_update_hazards();
    test_output_backpressure();
    test_random_traffic();
    wait_until_idle();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
